FILE: design/simplex_safety_arbiter_macros.svh
// Assertion macros for the safety arbiter RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef SIMPLEX_SAFETY_ARBITER_MACROS_SVH
`define SIMPLEX_SAFETY_ARBITER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ssa_pkg.sv
// Shared types, constants and helper functions for the safety arbiter.
// No dependencies; every other .sv design file imports this package.
`default_nettype none

package ssa_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int SCORE_WIDTH  = 32;
  localparam int DIGIT_WIDTH  = 4;
  localparam int SCORE_DIGITS = SCORE_WIDTH / DIGIT_WIDTH;
  localparam int DIG_CNT_W    = $clog2(SCORE_DIGITS + 1);
  localparam int FRAC_BITS    = 16;
  localparam int DIV_CNT_W    = $clog2(FRAC_BITS + 1);
  localparam int BLEND_WIDTH  = FRAC_BITS + 1;
  localparam int ADDR_WIDTH   = 5;
  localparam int DATA_WIDTH   = 32;

  localparam logic [BLEND_WIDTH-1:0] FULL_BLEND = BLEND_WIDTH'(1) << FRAC_BITS;
  localparam logic [BLEND_WIDTH-1:0] ZERO_BLEND = '0;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

  typedef enum logic [1:0] {
    MODE_NOMINAL    = 2'd0,
    MODE_HANDOFF    = 2'd1,
    MODE_FALLBACK   = 2'd2,
    MODE_RECOVERING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CALC,
    SEQ_SEND
  } seq_state_t;

  typedef enum logic [2:0] {
    REG_TRIP_LEVEL     = 3'd0,
    REG_CLEAR_LEVEL    = 3'd1,
    REG_TRIP_STREAK    = 3'd2,
    REG_CLEAR_STREAK   = 3'd3,
    REG_HANDOFF_LENGTH = 3'd4,
    REG_RECOVER_LENGTH = 3'd5,
    REG_MIN_FALLBACK   = 3'd6,
    REG_LATCH_FALLBACK = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SCORE_WIDTH-1:0] trip_level;
    logic [SCORE_WIDTH-1:0] clear_level;
    logic [COUNT_WIDTH-1:0] trip_streak_needed;
    logic [COUNT_WIDTH-1:0] clear_streak_needed;
    logic [COUNT_WIDTH-1:0] handoff_length;
    logic [COUNT_WIDTH-1:0] recover_length;
    logic [COUNT_WIDTH-1:0] min_fallback_time;
    logic                   latch_fallback;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic [SCORE_WIDTH-1:0] score;
    logic                   bad;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic over;
    logic under;
  } cmp_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] num;
    logic [COUNT_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/ssa_stream_if.sv
// Valid/ready channel interfaces for score beats in and result beats out.
// Depends on ssa_pkg for field widths.
`default_nettype none

interface ssa_in_if import ssa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SCORE_WIDTH-1:0] score;
  logic                   score_bad;

  modport source (output valid, output score, output score_bad, input ready);
  modport sink (input valid, input score, input score_bad, output ready);
endinterface

interface ssa_out_if import ssa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [BLEND_WIDTH-1:0] blend;

  modport source (output valid, output mode, output blend, input ready);
  modport sink (input valid, input mode, input blend, output ready);
endinterface

`default_nettype wire

FILE: design/ssa_cfg.sv
// APB-style configuration register file for the safety arbiter.
// Depends on ssa_pkg for the register map and the configuration struct.
`default_nettype none

module ssa_cfg import ssa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_reg_t idx;
  logic     wr_en;

  assign idx    = cfg_reg_t'(paddr[ADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_level          <= SCORE_WIDTH'(65536);
      cfg_r.clear_level         <= SCORE_WIDTH'(32768);
      cfg_r.trip_streak_needed  <= COUNT_WIDTH'(1);
      cfg_r.clear_streak_needed <= COUNT_WIDTH'(1);
      cfg_r.handoff_length      <= COUNT_WIDTH'(1);
      cfg_r.recover_length      <= COUNT_WIDTH'(1);
      cfg_r.min_fallback_time   <= '0;
      cfg_r.latch_fallback      <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIP_LEVEL:     cfg_r.trip_level          <= pwdata[SCORE_WIDTH-1:0];
        REG_CLEAR_LEVEL:    cfg_r.clear_level         <= pwdata[SCORE_WIDTH-1:0];
        REG_TRIP_STREAK:    cfg_r.trip_streak_needed  <= pwdata[COUNT_WIDTH-1:0];
        REG_CLEAR_STREAK:   cfg_r.clear_streak_needed <= pwdata[COUNT_WIDTH-1:0];
        REG_HANDOFF_LENGTH: cfg_r.handoff_length      <= pwdata[COUNT_WIDTH-1:0];
        REG_RECOVER_LENGTH: cfg_r.recover_length      <= pwdata[COUNT_WIDTH-1:0];
        REG_MIN_FALLBACK:   cfg_r.min_fallback_time   <= pwdata[COUNT_WIDTH-1:0];
        REG_LATCH_FALLBACK: cfg_r.latch_fallback      <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIP_LEVEL:     prdata = DATA_WIDTH'(cfg_r.trip_level);
      REG_CLEAR_LEVEL:    prdata = DATA_WIDTH'(cfg_r.clear_level);
      REG_TRIP_STREAK:    prdata = DATA_WIDTH'(cfg_r.trip_streak_needed);
      REG_CLEAR_STREAK:   prdata = DATA_WIDTH'(cfg_r.clear_streak_needed);
      REG_HANDOFF_LENGTH: prdata = DATA_WIDTH'(cfg_r.handoff_length);
      REG_RECOVER_LENGTH: prdata = DATA_WIDTH'(cfg_r.recover_length);
      REG_MIN_FALLBACK:   prdata = DATA_WIDTH'(cfg_r.min_fallback_time);
      REG_LATCH_FALLBACK: prdata = DATA_WIDTH'(cfg_r.latch_fallback);
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ssa_cmp.sv
// Digit-serial comparator of the score against the trip and clear levels.
// Depends on ssa_pkg; walks the score one digit per cycle from the low end.
`default_nettype none

module ssa_cmp import ssa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmp_req_t               req,
  input  wire logic [SCORE_WIDTH-1:0] trip_level,
  input  wire logic [SCORE_WIDTH-1:0] clear_level,
  output cmp_rsp_t                    rsp
);

  logic [SCORE_WIDTH-1:0] score_r, score_nxt;
  logic [SCORE_WIDTH-1:0] trip_r, trip_nxt;
  logic [SCORE_WIDTH-1:0] clear_r, clear_nxt;
  logic [DIG_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   gt_r, gt_nxt;
  logic                   lt_r, lt_nxt;
  logic                   bad_r, bad_nxt;
  logic [DIGIT_WIDTH-1:0] s_dig, t_dig, c_dig;

  assign s_dig = score_r[DIGIT_WIDTH-1:0];
  assign t_dig = trip_r[DIGIT_WIDTH-1:0];
  assign c_dig = clear_r[DIGIT_WIDTH-1:0];

  always_comb begin
    score_nxt = score_r;
    trip_nxt  = trip_r;
    clear_nxt = clear_r;
    cnt_nxt   = cnt_r;
    gt_nxt    = gt_r;
    lt_nxt    = lt_r;
    bad_nxt   = bad_r;
    if (req.start) begin
      score_nxt = req.score;
      trip_nxt  = trip_level;
      clear_nxt = clear_level;
      cnt_nxt   = DIG_CNT_W'(SCORE_DIGITS);
      gt_nxt    = 1'b0;
      lt_nxt    = 1'b0;
      bad_nxt   = req.bad;
    end else if (cnt_r != '0) begin
      // A higher digit overrides; equal digits keep the lower-digit verdict.
      gt_nxt    = (s_dig > t_dig) || ((s_dig == t_dig) && gt_r);
      lt_nxt    = (s_dig < c_dig) || ((s_dig == c_dig) && lt_r);
      score_nxt = score_r >> DIGIT_WIDTH;
      trip_nxt  = trip_r >> DIGIT_WIDTH;
      clear_nxt = clear_r >> DIGIT_WIDTH;
      cnt_nxt   = cnt_r - DIG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    trip_r  <= trip_nxt;
    clear_r <= clear_nxt;
    gt_r    <= gt_nxt;
    lt_r    <= lt_nxt;
    bad_r   <= bad_nxt;
  end

  assign rsp.done  = (cnt_r == '0);
  assign rsp.over  = bad_r || gt_r;
  assign rsp.under = !bad_r && lt_r;

endmodule

`default_nettype wire

FILE: design/ssa_div.sv
// Bit-serial restoring divider for the ramp fraction floor(num * 2^16 / den).
// Depends on ssa_pkg; produces one quotient bit per cycle, valid when num < den.
`default_nettype none

module ssa_div import ssa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] den_r, den_nxt;
  logic [FRAC_BITS-1:0]   quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_WIDTH:0]   shifted;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fits;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quot_nxt = '0;
      cnt_nxt  = DIV_CNT_W'(FRAC_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], fits};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = (cnt_r == '0);
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

FILE: design/simplex_safety_arbiter.sv
// Simplex safety arbiter: hysteresis switch between primary and fallback control.
// One tick in flight at a time: a new input beat is taken only after the last
// result has moved to the output register. The 16-step ramp divider is the slower
// serial unit; the 8-digit score compare runs alongside it. Synchronous active-low
// reset returns the control registers and counters to their defaults and the mode
// to nominal; the result register holds one finished beat while the next is taken.
`default_nettype none
`include "simplex_safety_arbiter_macros.svh"

module simplex_safety_arbiter import ssa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ssa_in_if.sink                     in_ch,
  ssa_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  cmp_req_t   cmp_req;
  cmp_rsp_t   cmp_rsp;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  seq_state_t seq_r, seq_nxt;
  mode_t      mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] ramp_r, ramp_nxt;
  logic [COUNT_WIDTH-1:0] fb_cnt_r, fb_cnt_nxt;
  logic [COUNT_WIDTH-1:0] ovs_r, ovs_nxt;
  logic [COUNT_WIDTH-1:0] uns_r, uns_nxt;
  mode_t                  res_mode_r, res_mode_nxt;
  logic [BLEND_WIDTH-1:0] res_blend_r, res_blend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mode_t                  out_mode_r;
  logic [BLEND_WIDTH-1:0] out_blend_r;

  logic                   accept;
  logic                   units_done;
  logic                   fin;
  logic                   slot_free;
  logic                   send;
  logic [COUNT_WIDTH-1:0] ramp_inc;
  logic [COUNT_WIDTH-1:0] fb_inc;
  logic [BLEND_WIDTH-1:0] frac;

  ssa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssa_cmp u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (cmp_req),
    .trip_level  (cfg.trip_level),
    .clear_level (cfg.clear_level),
    .rsp         (cmp_rsp)
  );

  ssa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign units_done = cmp_rsp.done && div_rsp.done;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign ramp_inc   = sat_inc(ramp_r);
  assign fb_inc     = sat_inc(fb_cnt_r);
  assign frac       = BLEND_WIDTH'(div_rsp.quot);

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SEQ_IDLE: if (in_ch.valid) seq_nxt = SEQ_CALC;
      SEQ_CALC: if (units_done) seq_nxt = SEQ_SEND;
      SEQ_SEND: if (slot_free) seq_nxt = SEQ_IDLE;
      default:  seq_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (seq_r == SEQ_IDLE);
    fin         = (seq_r == SEQ_CALC) && units_done;
    send        = (seq_r == SEQ_SEND) && slot_free;
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Both serial units start on the accepted beat; the divider works on the
  // incremented ramp, and the sequencer waits for both results before using it.
  always_comb begin
    cmp_req.start = accept;
    cmp_req.score = in_ch.score;
    cmp_req.bad   = in_ch.score_bad;
    div_req.start = accept;
    div_req.num   = ramp_inc;
    div_req.den   = (mode_r == MODE_HANDOFF) ? cfg.handoff_length : cfg.recover_length;
  end

  always_comb begin
    mode_nxt      = mode_r;
    ramp_nxt      = ramp_r;
    fb_cnt_nxt    = fb_cnt_r;
    ovs_nxt       = ovs_r;
    uns_nxt       = uns_r;
    res_mode_nxt  = res_mode_r;
    res_blend_nxt = res_blend_r;
    if (fin) begin
      ovs_nxt       = cmp_rsp.over ? sat_inc(ovs_r) : '0;
      uns_nxt       = cmp_rsp.under ? sat_inc(uns_r) : '0;
      res_blend_nxt = ZERO_BLEND;
      unique case (mode_r)
        MODE_NOMINAL: begin
          if (ovs_nxt >= cfg.trip_streak_needed) begin
            mode_nxt = MODE_HANDOFF;
            ramp_nxt = '0;
          end
        end
        MODE_HANDOFF: begin
          ramp_nxt = ramp_inc;
          if (ramp_inc >= cfg.handoff_length) begin
            mode_nxt      = MODE_FALLBACK;
            fb_cnt_nxt    = '0;
            res_blend_nxt = FULL_BLEND;
          end else begin
            res_blend_nxt = frac;
          end
        end
        MODE_FALLBACK: begin
          res_blend_nxt = FULL_BLEND;
          fb_cnt_nxt    = fb_inc;
          if (!cfg.latch_fallback && (fb_inc >= cfg.min_fallback_time) &&
              (uns_nxt >= cfg.clear_streak_needed)) begin
            mode_nxt = MODE_RECOVERING;
            ramp_nxt = '0;
          end
        end
        MODE_RECOVERING: begin
          if (ovs_nxt >= cfg.trip_streak_needed) begin
            mode_nxt      = MODE_FALLBACK;
            fb_cnt_nxt    = '0;
            res_blend_nxt = FULL_BLEND;
          end else begin
            ramp_nxt = ramp_inc;
            if (ramp_inc >= cfg.recover_length) begin
              mode_nxt      = MODE_NOMINAL;
              res_blend_nxt = ZERO_BLEND;
            end else begin
              res_blend_nxt = FULL_BLEND - frac;
            end
          end
        end
      endcase
      res_mode_nxt = mode_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (send) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_IDLE;
      mode_r      <= MODE_NOMINAL;
      ramp_r      <= '0;
      fb_cnt_r    <= '0;
      ovs_r       <= '0;
      uns_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      mode_r      <= mode_nxt;
      ramp_r      <= ramp_nxt;
      fb_cnt_r    <= fb_cnt_nxt;
      ovs_r       <= ovs_nxt;
      uns_r       <= uns_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_mode_r  <= res_mode_nxt;
    res_blend_r <= res_blend_nxt;
    if (send) begin
      out_mode_r  <= res_mode_r;
      out_blend_r <= res_blend_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.mode  = out_mode_r;
  assign out_ch.blend = out_blend_r;

  `SSA_ASSERT_NEXT(a_units_busy, accept, !units_done, "serial units did not start on accept")
  `SSA_ASSERT_NOW(a_fallback_full, out_valid_r && (out_mode_r == MODE_FALLBACK), out_blend_r == FULL_BLEND, "fallback beat without full blend")
  `SSA_ASSERT_NOW(a_nominal_zero, out_valid_r && (out_mode_r == MODE_NOMINAL), out_blend_r == ZERO_BLEND, "nominal beat with nonzero blend")

endmodule

`default_nettype wire
